@@ sv/mfmsec_pkg.sv @@
package mfmsec_pkg;

   localparam int WORDS_PER_SECTOR = 128;
   localparam int CNT_W            = $clog2(WORDS_PER_SECTOR);
   localparam int IDX_W            = 7;
   localparam int WORD_W           = 32;
   localparam int BURST_MAX        = 3;
   localparam int BURST_CNT_W      = 2;

   localparam logic [WORD_W-1:0] DATA_MASK  = 32'h5555_5555;
   localparam logic [WORD_W-1:0] CLOCK_MASK = 32'hAAAA_AAAA;

   typedef enum logic {
      KIND_DATA     = 1'b0,
      KIND_CHECKSUM = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [IDX_W-1:0]    word_index;
      logic [WORD_W-1:0]   odd_word;
      logic [WORD_W-1:0]   even_word;
      logic                last;
   } result_type;

   // one encoded word, or the three results closing a sector
   typedef struct packed {
      logic                              push;
      logic [BURST_CNT_W-1:0]            count;
      result_type [BURST_MAX-1:0]        slot;
   } burst_type;

   // MFM-encode the data bits of value; lead is the data bit ahead of the top cell
   function automatic logic [WORD_W-1:0] mfm_half(input logic [WORD_W-1:0] value,
                                                  input logic lead);
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] nbr;
      d   = value & DATA_MASK;
      nbr = (d >> 1) | (d << 1);
      nbr[WORD_W-1] = nbr[WORD_W-1] | lead;
      return d | (~nbr & CLOCK_MASK);
   endfunction

endpackage

@@ sv/mfmsec_req_if.sv @@
interface mfmsec_req_if;
   logic                            valid;
   logic                            ready;
   logic [mfmsec_pkg::WORD_W-1:0]   payload_word;
   logic                            preceding_bit;

   modport source (output valid, output payload_word, output preceding_bit, input ready);
   modport sink   (input valid, input payload_word, input preceding_bit, output ready);
endinterface

@@ sv/mfmsec_rsp_if.sv @@
interface mfmsec_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [mfmsec_pkg::IDX_W-1:0]    word_index;
   logic [mfmsec_pkg::WORD_W-1:0]   odd_word;
   logic [mfmsec_pkg::WORD_W-1:0]   even_word;
   logic                            last;

   modport source (output valid, output kind, output word_index, output odd_word,
                   output even_word, output last, input ready);
   modport sink   (input valid, input kind, input word_index, input odd_word,
                   input even_word, input last, output ready);
endinterface

@@ sv/mfmsec_core.sv @@
module mfmsec_core (
   input  logic                     clock,
   input  logic                     reset,
   mfmsec_req_if.sink               req_bus,
   output mfmsec_pkg::burst_type    burst,
   input  logic                     load_ok
);

   localparam logic [mfmsec_pkg::CNT_W-1:0] LAST_INDEX =
      mfmsec_pkg::CNT_W'(mfmsec_pkg::WORDS_PER_SECTOR - 1);

   logic                              in_valid_ff, in_valid_in;
   logic [mfmsec_pkg::WORD_W-1:0]     in_word_ff;
   logic                              in_pbit_ff;

   logic [mfmsec_pkg::CNT_W-1:0]      counter_ff, counter_in;
   logic [mfmsec_pkg::WORD_W-1:0]     first_ff, first_in;
   logic [mfmsec_pkg::WORD_W-1:0]     prev_ff, prev_in;
   logic [mfmsec_pkg::WORD_W-1:0]     cksum_ff, cksum_in;
   logic                              saved_pbit_ff, saved_pbit_in;

   logic                              accept;
   logic                              fire;
   logic                              is_head;
   logic                              is_final;
   logic [mfmsec_pkg::WORD_W-1:0]     odd_enc;
   logic [mfmsec_pkg::WORD_W-1:0]     even_enc;
   logic [mfmsec_pkg::WORD_W-1:0]     cksum_new;

   assign is_head  = (counter_ff == '0);
   assign is_final = (counter_ff == LAST_INDEX);
   // word 0 only updates state, so it never waits on the output side
   assign fire     = in_valid_ff & (is_head | load_ok);
   assign req_bus.ready = ~in_valid_ff | fire;
   assign accept   = req_bus.valid & req_bus.ready;

   assign cksum_new = cksum_ff ^ ((in_word_ff >> 1) & mfmsec_pkg::DATA_MASK)
                               ^ (in_word_ff & mfmsec_pkg::DATA_MASK);
   assign odd_enc   = mfmsec_pkg::mfm_half(in_word_ff >> 1, prev_ff[1]);
   assign even_enc  = mfmsec_pkg::mfm_half(in_word_ff, prev_ff[0]);

   always_comb begin
      in_valid_in   = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      counter_in    = counter_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      cksum_in      = cksum_ff;
      saved_pbit_in = saved_pbit_ff;
      if (fire) begin
         prev_in  = in_word_ff;
         if (is_head) begin
            first_in      = in_word_ff;
            saved_pbit_in = in_pbit_ff;
            cksum_in      = ((in_word_ff >> 1) & mfmsec_pkg::DATA_MASK)
                            ^ (in_word_ff & mfmsec_pkg::DATA_MASK);
            counter_in    = counter_ff + mfmsec_pkg::CNT_W'(1);
         end else begin
            cksum_in   = cksum_new;
            counter_in = is_final ? '0 : counter_ff + mfmsec_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      burst       = '0;
      burst.push  = fire & ~is_head;
      burst.count = is_final ? mfmsec_pkg::BURST_CNT_W'(3) : mfmsec_pkg::BURST_CNT_W'(1);

      burst.slot[0].kind       = mfmsec_pkg::KIND_DATA;
      burst.slot[0].word_index = mfmsec_pkg::IDX_W'(counter_ff);
      burst.slot[0].odd_word   = odd_enc;
      burst.slot[0].even_word  = even_enc;
      burst.slot[0].last       = ~is_final;

      burst.slot[1].kind       = mfmsec_pkg::KIND_CHECKSUM;
      burst.slot[1].word_index = '0;
      burst.slot[1].odd_word   = mfmsec_pkg::mfm_half(cksum_new >> 1, saved_pbit_ff);
      burst.slot[1].even_word  = mfmsec_pkg::mfm_half(cksum_new, cksum_new[1]);
      burst.slot[1].last       = 1'b0;

      // held word 0 closes the sector
      burst.slot[2].kind       = mfmsec_pkg::KIND_DATA;
      burst.slot[2].word_index = '0;
      burst.slot[2].odd_word   = mfmsec_pkg::mfm_half(first_ff >> 1, cksum_new[0]);
      burst.slot[2].even_word  = mfmsec_pkg::mfm_half(first_ff, in_word_ff[1]);
      burst.slot[2].last       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         counter_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         counter_ff  <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_bus.payload_word;
         in_pbit_ff <= req_bus.preceding_bit;
      end
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      cksum_ff      <= cksum_in;
      saved_pbit_ff <= saved_pbit_in;
   end

   a_final_wraps: assert property (@(posedge clock) disable iff (reset)
      fire && is_final |=> counter_ff == '0)
      else $error("counter did not wrap after final word");

   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      counter_ff <= LAST_INDEX)
      else $error("word counter beyond sector length");

   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_word_ff))
      else $error("stalled input word changed");

endmodule

@@ sv/mfmsec_out_buf.sv @@
module mfmsec_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  mfmsec_pkg::burst_type    burst,
   output logic                     load_ok,
   mfmsec_rsp_if.source             rsp_bus
);

   mfmsec_pkg::result_type [mfmsec_pkg::BURST_MAX-1:0] slot_ff, slot_in;
   logic [mfmsec_pkg::BURST_CNT_W-1:0]                 count_ff, count_in;
   logic                                               pop;

   assign rsp_bus.valid      = (count_ff != '0);
   assign pop                = rsp_bus.valid & rsp_bus.ready;
   assign load_ok            = (count_ff == '0)
                               | ((count_ff == mfmsec_pkg::BURST_CNT_W'(1)) & pop);
   assign rsp_bus.kind       = slot_ff[0].kind;
   assign rsp_bus.word_index = slot_ff[0].word_index;
   assign rsp_bus.odd_word   = slot_ff[0].odd_word;
   assign rsp_bus.even_word  = slot_ff[0].even_word;
   assign rsp_bus.last       = slot_ff[0].last;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (burst.push) begin
         slot_in  = burst.slot;
         count_in = burst.count;
      end else if (pop) begin
         // advance the queue by one slot
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - mfmsec_pkg::BURST_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      burst.push |-> count_ff == '0 || (count_ff == mfmsec_pkg::BURST_CNT_W'(1) && pop))
      else $error("burst loaded over pending results");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      pop && slot_ff[0].last |-> count_ff == mfmsec_pkg::BURST_CNT_W'(1))
      else $error("results pending behind a last result");

   a_cksum_then_word0: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && slot_ff[0].kind == mfmsec_pkg::KIND_CHECKSUM
      |-> count_ff == mfmsec_pkg::BURST_CNT_W'(2) && slot_ff[1].word_index == '0)
      else $error("checksum not followed by word 0");

   a_pop_continues: assert property (@(posedge clock) disable iff (reset)
      pop && count_ff > mfmsec_pkg::BURST_CNT_W'(1) |=> rsp_bus.valid)
      else $error("pending results lost");

endmodule

@@ sv/mfm_sector_encoder_checksum_unit.sv @@
// MFM sector payload encoder with running sector checksum.
//
// req_bus carries one raw payload longword per transfer, word 0 first;
// preceding_bit is sampled only with word 0 and sets the clock bit in front
// of the checksum's odd half. rsp_bus carries encoded odd/even longword pairs.
// Word 0 produces no transfer; each middle word produces one (last = 1); the
// final word of a sector produces three: its own encoding, the encoded
// checksum (kind = 1), then the held word 0 (last = 1 on this one).
//
// Each result passes through the input register, then the result register,
// before it is valid on rsp_bus. With rsp_bus.ready held high the block takes
// one word per cycle, but word 1 of the next sector waits in the input register
// while the three-slot result register drains.
//
// Reset clears the word counter and both valid flags; the next transfer is
// taken as word 0. When the receiver stalls, results hold in the result
// register, then the input register fills and req_bus.ready drops.
module mfm_sector_encoder_checksum_unit (
   input  logic          clock,
   input  logic          reset,
   mfmsec_req_if.sink    req_bus,
   mfmsec_rsp_if.source  rsp_bus
);

   mfmsec_pkg::burst_type  burst;
   logic                   load_ok;

   // input register, sector state and encoding logic
   mfmsec_core u_core (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .burst   (burst),
      .load_ok (load_ok)
   );

   // result register: hold up to three results, drain one per transfer
   mfmsec_out_buf u_out_buf (
      .clock   (clock),
      .reset   (reset),
      .burst   (burst),
      .load_ok (load_ok),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ test/mfmsec_scoreboard.sv @@
`timescale 1ns / 100ps

module mfmsec_scoreboard (
   input  logic   clock,
   input  logic   reset,
   mfmsec_req_if  req_mon,
   mfmsec_rsp_if  rsp_mon,
   output int     mismatches,
   output int     outstanding,
   output int     results_checked,
   output int     sectors_closed
);

   // encoder state, mirrored from the block
   logic [mfmsec_pkg::WORD_W-1:0] held_first;
   logic [mfmsec_pkg::WORD_W-1:0] prior_word;
   logic [mfmsec_pkg::WORD_W-1:0] sector_sum;
   logic                          sector_lead;
   int                            word_pos;

   mfmsec_pkg::result_type pending_results[$];

   // Build the MFM cells of the even data bits of bits, one clock bit per cell.
   // A clock bit is set only when the data bits on both sides are clear.
   function automatic logic [mfmsec_pkg::WORD_W-1:0] mfm_cells(
      input logic [mfmsec_pkg::WORD_W-1:0] bits,
      input logic lead);
      logic [mfmsec_pkg::WORD_W-1:0] coded;
      logic                          left;
      coded = '0;
      for (int c = 0; c < mfmsec_pkg::WORD_W / 2; c++) begin
         if (c == mfmsec_pkg::WORD_W / 2 - 1) begin
            left = lead;
         end else begin
            left = bits[2*c+2];
         end
         coded[2*c]   = bits[2*c];
         coded[2*c+1] = ~(left | bits[2*c]);
      end
      return coded;
   endfunction

   task automatic queue_result(input mfmsec_pkg::kind_type k,
                               input logic [mfmsec_pkg::IDX_W-1:0] idx,
                               input logic [mfmsec_pkg::WORD_W-1:0] odd_h,
                               input logic [mfmsec_pkg::WORD_W-1:0] even_h,
                               input logic fin);
      mfmsec_pkg::result_type r;
      r.kind       = k;
      r.word_index = idx;
      r.odd_word   = odd_h;
      r.even_word  = even_h;
      r.last       = fin;
      pending_results.push_back(r);
   endtask

   task automatic encode_sector_word(input logic [mfmsec_pkg::WORD_W-1:0] w,
                                     input logic pb);
      logic [mfmsec_pkg::WORD_W-1:0] odd_h;
      logic [mfmsec_pkg::WORD_W-1:0] even_h;
      if (word_pos == 0) begin
         held_first  = w;
         prior_word  = w;
         sector_lead = pb;
         sector_sum  = ((w >> 1) & mfmsec_pkg::DATA_MASK) ^ (w & mfmsec_pkg::DATA_MASK);
         word_pos    = 1;
      end else begin
         odd_h      = mfm_cells(w >> 1, prior_word[1]);
         even_h     = mfm_cells(w, prior_word[0]);
         sector_sum = (sector_sum ^ odd_h ^ even_h) & mfmsec_pkg::DATA_MASK;
         prior_word = w;
         if (word_pos + 1 < mfmsec_pkg::WORDS_PER_SECTOR) begin
            queue_result(mfmsec_pkg::KIND_DATA, mfmsec_pkg::IDX_W'(word_pos),
                         odd_h, even_h, 1'b1);
            word_pos++;
         end else begin
            queue_result(mfmsec_pkg::KIND_DATA, mfmsec_pkg::IDX_W'(word_pos),
                         odd_h, even_h, 1'b0);
            queue_result(mfmsec_pkg::KIND_CHECKSUM, '0,
                         mfm_cells(sector_sum >> 1, sector_lead),
                         mfm_cells(sector_sum, sector_sum[1]), 1'b0);
            queue_result(mfmsec_pkg::KIND_DATA, '0,
                         mfm_cells(held_first >> 1, sector_sum[0]),
                         mfm_cells(held_first, prior_word[1]), 1'b1);
            word_pos = 0;
            sectors_closed++;
         end
      end
   endtask

   task automatic check_field(input string field,
                              input logic [mfmsec_pkg::WORD_W-1:0] want,
                              input logic [mfmsec_pkg::WORD_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      results_checked = 0;
      sectors_closed  = 0;
      word_pos        = 0;
      held_first      = '0;
      prior_word      = '0;
      sector_sum      = '0;
      sector_lead     = 1'b0;
   end

   always @(posedge clock) begin
      mfmsec_pkg::result_type want;
      if (reset) begin
         word_pos    = 0;
         held_first  = '0;
         prior_word  = '0;
         sector_sum  = '0;
         sector_lead = 1'b0;
         pending_results.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            encode_sector_word(req_mon.payload_word, req_mon.preceding_bit);
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %h/%h",
                        $time, rsp_mon.odd_word, rsp_mon.even_word);
            end else begin
               want = pending_results.pop_front();
               check_field("kind", mfmsec_pkg::WORD_W'(want.kind),
                           mfmsec_pkg::WORD_W'(rsp_mon.kind));
               check_field("word_index", mfmsec_pkg::WORD_W'(want.word_index),
                           mfmsec_pkg::WORD_W'(rsp_mon.word_index));
               check_field("odd_word", want.odd_word, rsp_mon.odd_word);
               check_field("even_word", want.even_word, rsp_mon.even_word);
               check_field("last", mfmsec_pkg::WORD_W'(want.last),
                           mfmsec_pkg::WORD_W'(rsp_mon.last));
               results_checked++;
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   // two full sectors, then the head of a third so the block ends mid-sector
   localparam int TOTAL_WORDS  = 2 * mfmsec_pkg::WORDS_PER_SECTOR + 20;
   localparam int DIRECTED_CNT = 24;
   // sender offers back to back over this window while the receiver holds off
   localparam int PRESS_FIRST  = 24;
   localparam int PRESS_LAST   = 100;
   localparam int HOLD_AFTER   = 30;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 12;

   logic clock;
   logic reset;
   logic req_taken;
   logic rsp_taken;

   int mismatches;
   int outstanding;
   int results_checked;
   int sectors_closed;
   int send_mode;
   int recv_mode;
   int drained;

   logic [mfmsec_pkg::WORD_W-1:0] directed_words [DIRECTED_CNT];

   mfmsec_req_if req_bus ();
   mfmsec_rsp_if rsp_bus ();

   mfm_sector_encoder_checksum_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mfmsec_scoreboard scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .sectors_closed  (sectors_closed)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Latch each transfer at the rising edge; the driving processes look at
   // these at the following falling edge, so they never race the block.
   always @(posedge clock) begin
      req_taken <= req_bus.valid && req_bus.ready;
      rsp_taken <= rsp_bus.valid && rsp_bus.ready;
   end

   // Draw an idle count: zero, short or full range, depending on the mode
   // that is redrawn every sixteen transfers.
   function automatic int draw_idle(input int mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(0, 3);
         default: return $urandom_range(0, 14);
      endcase
   endfunction

   // Pick a payload word; lean on the bit patterns that stress the clock
   // bits (all clear, all set, data-only, clock-only, single bits).
   function automatic logic [mfmsec_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return mfmsec_pkg::DATA_MASK;
         3:       return mfmsec_pkg::CLOCK_MASK;
         4:       return mfmsec_pkg::WORD_W'(1) << $urandom_range(0, mfmsec_pkg::WORD_W - 1);
         5:       return ~(mfmsec_pkg::WORD_W'(1) << $urandom_range(0, mfmsec_pkg::WORD_W - 1));
         default: return $urandom;
      endcase
   endfunction

   // Offer one payload word and hold it until the transfer. Called at a
   // falling edge; valid is assigned at most once per edge, so a word that
   // follows with no gap keeps valid high without a glitch.
   task automatic send_word(input logic [mfmsec_pkg::WORD_W-1:0] w, input logic pb,
                            input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.payload_word  <= w;
      req_bus.preceding_bit <= pb;
      do @(negedge clock); while (req_taken !== 1'b1);
   endtask

   initial begin
      directed_words = '{
         32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
         32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h0000_0001,
         32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'h5555_5555,
         32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'h4000_0002,
         32'h0000_0003, 32'hC000_0000, 32'h2AAA_AAAA, 32'hD555_5555
      };
   end

   // Sender: directed words first, then random words; the block takes
   // any order of words, so every word is well formed.
   initial begin
      logic [mfmsec_pkg::WORD_W-1:0] w;
      logic                          pb;
      int                            gap;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.payload_word  = '0;
      req_bus.preceding_bit = 1'b0;
      send_mode             = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < TOTAL_WORDS; i++) begin
         if (i % 16 == 0)
            send_mode = $urandom_range(0, 2);
         w  = (i < DIRECTED_CNT) ? directed_words[i] : pick_word();
         pb = 1'($urandom_range(0, 1));
         // first sector opens with the lead bit set, the second with it clear
         if (i == 0)
            pb = 1'b1;
         else if (i == mfmsec_pkg::WORDS_PER_SECTOR)
            pb = 1'b0;
         gap = (i >= PRESS_FIRST && i <= PRESS_LAST) ? 0 : draw_idle(send_mode);
         send_word(w, pb, gap);
      end
      req_bus.valid <= 1'b0;

      // drain: all predictions answered, then a few quiet cycles to catch
      // any stray result
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d payload words, closed %0d sectors, checked %0d encoded results",
               TOTAL_WORDS, sectors_closed, results_checked);
      $display("Idle gaps on both sides, plus one %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver: stall a random count before each result; once, after a few
   // dozen results, hold off long enough for the block to fill and stall
   // its input.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      recv_mode     = 0;
      drained       = 0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (drained % 16 == 0)
            recv_mode = $urandom_range(0, 2);
         stall = (drained == HOLD_AFTER) ? HOLD_CYCLES : draw_idle(recv_mode);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(negedge clock); while (rsp_taken !== 1'b1);
         drained++;
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ mfm_sector_encoder_checksum_unit.f @@
sv/mfmsec_pkg.sv
sv/mfmsec_req_if.sv
sv/mfmsec_rsp_if.sv
sv/mfmsec_core.sv
sv/mfmsec_out_buf.sv
sv/mfm_sector_encoder_checksum_unit.sv
test/mfmsec_scoreboard.sv
test/testbench.sv
